// ===== src/assert_macros.svh =====
// assertion helpers, empty when synthesizing
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define AMGS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication failed");

// next-cycle implication
`define AMGS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication failed");

`else

`define AMGS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define AMGS_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== src/amgs_pkg.sv =====
package amgs_pkg;

	// default sizes
	localparam int MAX_VERTICES_DEF = 32;
	localparam int WEIGHT_BITS_DEF  = 16;

	// port field widths
	localparam int MODE_W   = 2;
	localparam int VTX_W    = 5;
	localparam int WIN_W    = 16;
	localparam int KIND_W   = 3;
	localparam int WOUT_W   = 16;
	localparam int VCOUNT_W = 6;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	typedef enum logic [MODE_W-1:0] {
		M_INSERT = 2'd0,
		M_REMOVE = 2'd1,
		M_LIST   = 2'd2,
		M_MIN    = 2'd3
	} mode_t;

	typedef enum logic [KIND_W-1:0] {
		K_DONE    = 3'd0,
		K_NEIGH   = 3'd1,
		K_NONEIGH = 3'd2,
		K_MIN     = 3'd3,
		K_NOEDGE  = 3'd4,
		K_RANGE   = 3'd5
	} kind_t;

	typedef enum logic [0:0] {
		REG_IS_DIRECTED  = 1'b0,
		REG_VERTEX_COUNT = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UPD_FWD,
		ST_UPD_MIR,
		ST_LIST_LD,
		ST_LIST,
		ST_MIN_ROW,
		ST_MIN_SCAN,
		ST_MIN_FIN,
		ST_MIN_EMIT
	} state_t;

endpackage

// ===== src/amgs_ram.sv =====
module amgs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== src/adjacency_matrix_graph_store_unit.sv =====
// Weighted adjacency-matrix graph store. A command is taken when start is high and busy is low;
// its results come out one per strobe cycle on result_strobe and cannot be held off, with last
// set on the final one. Insert and remove write the forward cell, then the mirror cell when an
// undirected edge is mirrored. Listing loads the vertex's row, then steps column by column up to
// its highest neighbour. The minimum search reads every in-range cell through the single weight
// memory read port, row by row. Out-of-range commands, and a minimum search with no vertex in
// use, answer in the next cycle without raising busy. Edge presence is held as one row per
// vertex with a valid flag per row, so no clearing pass follows reset; a weight is only used
// when its cell is present.
`include "assert_macros.svh"

module adjacency_matrix_graph_store_unit
	import amgs_pkg::*;
#(
	parameter int MAX_VERTICES = MAX_VERTICES_DEF,
	parameter int WEIGHT_BITS  = WEIGHT_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// command side
	input  logic                start,
	output logic                busy,
	input  logic [MODE_W-1:0]   mode,
	input  logic [VTX_W-1:0]    source_vertex,
	input  logic [VTX_W-1:0]    dest_vertex,
	input  logic [WIN_W-1:0]    edge_weight,
	// result side
	output logic                result_strobe,
	output logic [KIND_W-1:0]   kind,
	output logic [VTX_W-1:0]    vertex_a,
	output logic [VTX_W-1:0]    vertex_b,
	output logic [WOUT_W-1:0]   weight_out,
	output logic                last,
	// configuration port
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output logic [PDATA_W-1:0]  prdata,
	output logic                pready
);

	localparam int VW        = $clog2(MAX_VERTICES);
	localparam int NW        = $clog2(MAX_VERTICES + 1);
	localparam int WT_AW     = 2 * VW;
	localparam int WT_DEPTH  = 1 << WT_AW;

	// configuration registers
	logic                 is_directed_q;
	logic [VCOUNT_W-1:0]  vertex_count_q;
	logic                 cfg_we;
	reg_idx_t             reg_idx;

	// sequencer
	state_t state_q, state_d;
	logic   accept;

	// latched command
	mode_t                mode_q;
	logic [VW-1:0]        src_q;
	logic [VW-1:0]        dst_q;
	logic [WEIGHT_BITS-1:0] wt_q;

	// vertices in use, saturated at the matrix size
	logic [NW-1:0]        n_eff;
	logic [MAX_VERTICES-1:0] colmask;
	logic                 src_ok;
	logic                 dst_ok;

	// presence rows
	logic [MAX_VERTICES-1:0] row_vld_q;
	logic                 rd_vld_s1;
	logic                 row_we;
	logic [VW-1:0]        row_waddr;
	logic [MAX_VERTICES-1:0] row_wdata;
	logic [VW-1:0]        row_raddr;
	logic [MAX_VERTICES-1:0] row_rdata;
	logic [MAX_VERTICES-1:0] row_rd;
	logic [MAX_VERTICES-1:0] row_in_use;

	// weights
	logic                 wt_we;
	logic [WT_AW-1:0]     wt_waddr;
	logic [WEIGHT_BITS-1:0] wt_wdata;
	logic [WEIGHT_BITS-1:0] wt_rdata;

	// scanning
	logic [MAX_VERTICES-1:0] list_row_q;
	logic [MAX_VERTICES-1:0] list_rem;
	logic [MAX_VERTICES-1:0] scan_row_q;
	logic [VW-1:0]        col_q;
	logic [VW-1:0]        row_q;
	logic                 col_last;
	logic                 row_last;
	logic                 mirror;

	// minimum compare stage, registered in step with the weight read data
	logic                 cmp_vld_s1;
	logic [VW-1:0]        cmp_a_s1;
	logic [VW-1:0]        cmp_b_s1;
	logic                 found_q;
	logic [WEIGHT_BITS-1:0] best_q;
	logic [VW-1:0]        best_a_q;
	logic [VW-1:0]        best_b_q;

	// result to be registered
	logic                 emit_en;
	kind_t                emit_kind;
	logic [VW-1:0]        emit_a;
	logic [VW-1:0]        emit_b;
	logic [WEIGHT_BITS-1:0] emit_w;
	logic                 emit_last;

	// result registers
	logic                 strobe_q;
	kind_t                kind_q;
	logic [VW-1:0]        va_q;
	logic [VW-1:0]        vb_q;
	logic [WEIGHT_BITS-1:0] wout_q;
	logic                 last_q;

	// ---------------------------------------------------------------
	// configuration port, writes take effect on the access-phase edge
	// ---------------------------------------------------------------
	assign pready  = 1'b1;
	assign cfg_we  = psel & penable & pwrite & pready;
	assign reg_idx = reg_idx_t'(paddr[2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_directed_q  <= 1'b1;
			vertex_count_q <= VCOUNT_W'(32);
		end else if (cfg_we) begin
			case (reg_idx)
				REG_IS_DIRECTED:  is_directed_q  <= pwdata[0];
				REG_VERTEX_COUNT: vertex_count_q <= pwdata[VCOUNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_IS_DIRECTED:  prdata = PDATA_W'(is_directed_q);
			REG_VERTEX_COUNT: prdata = PDATA_W'(vertex_count_q);
			default:          prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------
	// vertex range
	// ---------------------------------------------------------------
	always_comb begin
		if (int'(vertex_count_q) > MAX_VERTICES) begin
			n_eff = NW'(MAX_VERTICES);
		end else begin
			n_eff = NW'(vertex_count_q);
		end
	end

	always_comb begin
		for (int i = 0; i < MAX_VERTICES; i++) begin
			colmask[i] = (i < int'(n_eff));
		end
	end

	assign src_ok   = int'(source_vertex) < int'(n_eff);
	assign dst_ok   = int'(dest_vertex) < int'(n_eff);
	assign col_last = int'(col_q) == int'(n_eff) - 1;
	assign row_last = int'(row_q) == int'(n_eff) - 1;
	assign mirror   = !is_directed_q && (src_q != dst_q);

	assign busy   = (state_q != ST_IDLE);
	assign accept = start & !busy;

	// ---------------------------------------------------------------
	// memories
	// ---------------------------------------------------------------
	amgs_ram #(
		.WIDTH(MAX_VERTICES),
		.DEPTH(MAX_VERTICES)
	) u_row_ram (
		.clk  (clk),
		.we   (row_we),
		.waddr(row_waddr),
		.wdata(row_wdata),
		.raddr(row_raddr),
		.rdata(row_rdata)
	);

	amgs_ram #(
		.WIDTH(WEIGHT_BITS),
		.DEPTH(WT_DEPTH)
	) u_wt_ram (
		.clk  (clk),
		.we   (wt_we),
		.waddr(wt_waddr),
		.wdata(wt_wdata),
		.raddr({row_q, col_q}),
		.rdata(wt_rdata)
	);

	// a row never written reads as empty
	assign row_rd     = rd_vld_s1 ? row_rdata : '0;
	assign row_in_use = row_rd & colmask;

	// list row with the current column dropped
	always_comb begin
		list_rem        = list_row_q;
		list_rem[col_q] = 1'b0;
	end

	// ---------------------------------------------------------------
	// next state
	// ---------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					case (mode_t'(mode))
						M_INSERT, M_REMOVE: if (src_ok && dst_ok) state_d = ST_UPD_FWD;
						M_LIST:             if (src_ok) state_d = ST_LIST_LD;
						M_MIN:              if (n_eff != '0) state_d = ST_MIN_ROW;
						default:            state_d = ST_IDLE;
					endcase
				end
			end
			ST_UPD_FWD:  state_d = mirror ? ST_UPD_MIR : ST_IDLE;
			ST_UPD_MIR:  state_d = ST_IDLE;
			ST_LIST_LD:  state_d = (row_in_use == '0) ? ST_IDLE : ST_LIST;
			ST_LIST: begin
				if (list_row_q[col_q] && (list_rem == '0)) state_d = ST_IDLE;
			end
			ST_MIN_ROW:  state_d = ST_MIN_SCAN;
			ST_MIN_SCAN: begin
				if (col_last) state_d = row_last ? ST_MIN_FIN : ST_MIN_ROW;
			end
			ST_MIN_FIN:  state_d = ST_MIN_EMIT;
			ST_MIN_EMIT: state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// ---------------------------------------------------------------
	// memory controls and results per state
	// ---------------------------------------------------------------
	always_comb begin
		row_we    = 1'b0;
		row_waddr = src_q;
		row_wdata = row_rd;
		row_raddr = src_q;
		wt_we     = 1'b0;
		wt_waddr  = {src_q, dst_q};
		wt_wdata  = wt_q;
		emit_en   = 1'b0;
		emit_kind = K_DONE;
		emit_a    = '0;
		emit_b    = '0;
		emit_w    = '0;
		emit_last = 1'b1;
		case (state_q)
			ST_IDLE: begin
				// start the row read for whatever the command needs first
				row_raddr = (mode_t'(mode) == M_MIN) ? '0 : VW'(source_vertex);
				if (accept) begin
					case (mode_t'(mode))
						M_INSERT, M_REMOVE: begin
							if (!(src_ok && dst_ok)) begin
								emit_en   = 1'b1;
								emit_kind = K_RANGE;
							end
						end
						M_LIST: begin
							if (!src_ok) begin
								emit_en   = 1'b1;
								emit_kind = K_RANGE;
							end
						end
						M_MIN: begin
							if (n_eff == '0) begin
								emit_en   = 1'b1;
								emit_kind = K_NOEDGE;
							end
						end
						default: ;
					endcase
				end
			end
			ST_UPD_FWD: begin
				// forward cell, and fetch the mirror row
				row_we             = 1'b1;
				row_waddr          = src_q;
				row_wdata          = row_rd;
				row_wdata[dst_q]   = (mode_q == M_INSERT);
				row_raddr          = dst_q;
				wt_we              = (mode_q == M_INSERT);
				wt_waddr           = {src_q, dst_q};
				if (!mirror) begin
					emit_en   = 1'b1;
					emit_kind = K_DONE;
				end
			end
			ST_UPD_MIR: begin
				row_we             = 1'b1;
				row_waddr          = dst_q;
				row_wdata          = row_rd;
				row_wdata[src_q]   = (mode_q == M_INSERT);
				wt_we              = (mode_q == M_INSERT);
				wt_waddr           = {dst_q, src_q};
				emit_en            = 1'b1;
				emit_kind          = K_DONE;
			end
			ST_LIST_LD: begin
				if (row_in_use == '0) begin
					emit_en   = 1'b1;
					emit_kind = K_NONEIGH;
				end
			end
			ST_LIST: begin
				if (list_row_q[col_q]) begin
					emit_en   = 1'b1;
					emit_kind = K_NEIGH;
					emit_a    = col_q;
					emit_last = (list_rem == '0);
				end
			end
			ST_MIN_SCAN: begin
				// prefetch the next row while the current one finishes
				row_raddr = row_q + VW'(1);
			end
			ST_MIN_EMIT: begin
				emit_en = 1'b1;
				if (found_q) begin
					emit_kind = K_MIN;
					emit_w    = best_q;
					// undirected: smaller vertex first
					if (!is_directed_q && (best_b_q < best_a_q)) begin
						emit_a = best_b_q;
						emit_b = best_a_q;
					end else begin
						emit_a = best_a_q;
						emit_b = best_b_q;
					end
				end else begin
					emit_kind = K_NOEDGE;
				end
			end
			default: ;
		endcase
	end

	// ---------------------------------------------------------------
	// control registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			row_vld_q  <= '0;
			rd_vld_s1  <= 1'b0;
			cmp_vld_s1 <= 1'b0;
			found_q    <= 1'b0;
			strobe_q   <= 1'b0;
		end else begin
			state_q   <= state_d;
			rd_vld_s1 <= row_vld_q[row_raddr];
			if (row_we) begin
				row_vld_q[row_waddr] <= 1'b1;
			end
			cmp_vld_s1 <= (state_q == ST_MIN_SCAN) && scan_row_q[col_q];
			if (accept) begin
				found_q <= 1'b0;
			end else if (cmp_vld_s1 && (!found_q || (wt_rdata < best_q))) begin
				found_q <= 1'b1;
			end
			strobe_q <= emit_en;
		end
	end

	// ---------------------------------------------------------------
	// payload registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= mode_t'(mode);
			src_q  <= VW'(source_vertex);
			dst_q  <= VW'(dest_vertex);
			wt_q   <= WEIGHT_BITS'(edge_weight);
			row_q  <= '0;
			col_q  <= '0;
		end else begin
			case (state_q)
				ST_LIST_LD: begin
					list_row_q <= row_in_use;
					col_q      <= '0;
				end
				ST_LIST: begin
					list_row_q[col_q] <= 1'b0;
					col_q             <= col_q + VW'(1);
				end
				ST_MIN_ROW: begin
					scan_row_q <= row_in_use;
					col_q      <= '0;
				end
				ST_MIN_SCAN: begin
					col_q <= col_q + VW'(1);
					if (col_last) begin
						row_q <= row_q + VW'(1);
					end
				end
				default: ;
			endcase
		end
		cmp_a_s1 <= row_q;
		cmp_b_s1 <= col_q;
		// first strictly smaller weight wins
		if (cmp_vld_s1 && (!found_q || (wt_rdata < best_q))) begin
			best_q   <= wt_rdata;
			best_a_q <= cmp_a_s1;
			best_b_q <= cmp_b_s1;
		end
		if (emit_en) begin
			kind_q <= emit_kind;
			va_q   <= emit_a;
			vb_q   <= emit_b;
			wout_q <= emit_w;
			last_q <= emit_last;
		end
	end

	assign result_strobe = strobe_q;
	assign kind          = kind_q;
	assign vertex_a      = VTX_W'(va_q);
	assign vertex_b      = VTX_W'(vb_q);
	assign weight_out    = WOUT_W'(wout_q);
	assign last          = last_q;

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	// the final result of a command leaves the sequencer free
	`AMGS_ASSERT_IMP(a_last_idle, clk, arst_n, strobe_q && last_q, !busy)
	// more neighbours pending means the listing is still running
	`AMGS_ASSERT_IMP(a_more_busy, clk, arst_n, strobe_q && !last_q, state_q == ST_LIST)
	// only neighbour transfers can be non-final
	`AMGS_ASSERT_IMP(a_single_last, clk, arst_n, strobe_q && (kind_q != K_NEIGH), last_q)
	// an accepted command either answers at once or keeps the block busy
	`AMGS_ASSERT_NXT(a_accept_progress, clk, arst_n, accept, strobe_q || busy)

endmodule

// ===== tb/graph_store_checker.sv =====
`timescale 1ns / 1ps

module graph_store_checker
	import amgs_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                busy,
	input  logic [MODE_W-1:0]   mode,
	input  logic [VTX_W-1:0]    source_vertex,
	input  logic [VTX_W-1:0]    dest_vertex,
	input  logic [WIN_W-1:0]    edge_weight,
	input  logic                result_strobe,
	input  logic [KIND_W-1:0]   kind,
	input  logic [VTX_W-1:0]    vertex_a,
	input  logic [VTX_W-1:0]    vertex_b,
	input  logic [WOUT_W-1:0]   weight_out,
	input  logic                last,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic                pready,
	input  logic [PADDR_W-1:0]  paddr,
	input  logic [PDATA_W-1:0]  pwdata,
	output int unsigned         pending_results,
	output int unsigned         mismatch_count
);

	localparam int MAXV = MAX_VERTICES_DEF;

	typedef struct {
		kind_t             kind;
		logic [VTX_W-1:0]  va;
		logic [VTX_W-1:0]  vb;
		logic [WOUT_W-1:0] w;
		logic              last;
	} graph_result_t;

	// shadow of the matrix and the registers
	bit                edge_on [MAXV][MAXV];
	logic [WOUT_W-1:0] edge_w  [MAXV][MAXV];
	logic              directed;
	logic [VCOUNT_W-1:0] vcount;

	graph_result_t expected_q [$];

	task automatic flag_error(input string msg);
		$display("[%0t] graph check: %s", $time, msg);
		mismatch_count++;
	endtask

	function automatic void push_result(kind_t k, int a, int b, int w, bit l);
		graph_result_t r;
		r.kind = k;
		r.va   = VTX_W'(a);
		r.vb   = VTX_W'(b);
		r.w    = WOUT_W'(w);
		r.last = l;
		expected_q.push_back(r);
	endfunction

	// works out the results of one command and applies it to the shadow matrix
	function automatic void predict_command(mode_t m, int s, int d, logic [WOUT_W-1:0] w);
		int n;
		int top;
		bit found;
		logic [WOUT_W-1:0] best;
		int ba;
		int bb;
		int t;
		n = (vcount > MAXV) ? MAXV : int'(vcount);
		case (m)
			M_INSERT, M_REMOVE: begin
				if (s >= n || d >= n) begin
					push_result(K_RANGE, 0, 0, 0, 1'b1);
				end else begin
					edge_on[s][d] = (m == M_INSERT);
					if (m == M_INSERT)
						edge_w[s][d] = w;
					if (!directed) begin
						edge_on[d][s] = (m == M_INSERT);
						if (m == M_INSERT)
							edge_w[d][s] = w;
					end
					push_result(K_DONE, 0, 0, 0, 1'b1);
				end
			end
			M_LIST: begin
				if (s >= n) begin
					push_result(K_RANGE, 0, 0, 0, 1'b1);
				end else begin
					top = -1;
					for (int i = 0; i < n; i++)
						if (edge_on[s][i])
							top = i;
					if (top < 0) begin
						push_result(K_NONEIGH, 0, 0, 0, 1'b1);
					end else begin
						for (int i = 0; i <= top; i++)
							if (edge_on[s][i])
								push_result(K_NEIGH, i, 0, 0, i == top);
					end
				end
			end
			default: begin
				found = 1'b0;
				best = '0;
				ba = 0;
				bb = 0;
				for (int i = 0; i < n; i++)
					for (int j = 0; j < n; j++)
						if (edge_on[i][j] && (!found || edge_w[i][j] < best)) begin
							found = 1'b1;
							best = edge_w[i][j];
							ba = i;
							bb = j;
						end
				if (!found) begin
					push_result(K_NOEDGE, 0, 0, 0, 1'b1);
				end else begin
					if (!directed && bb < ba) begin
						t = ba;
						ba = bb;
						bb = t;
					end
					push_result(K_MIN, ba, bb, best, 1'b1);
				end
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		graph_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < MAXV; i++)
				for (int j = 0; j < MAXV; j++)
					edge_on[i][j] = 1'b0;
			directed = 1'b1;
			vcount = VCOUNT_W'(32);
			expected_q.delete();
			mismatch_count = 0;
			pending_results <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_idx_t'(paddr[2]))
					REG_IS_DIRECTED:  directed = pwdata[0];
					REG_VERTEX_COUNT: vcount = pwdata[VCOUNT_W-1:0];
					default: ;
				endcase
			end
			if (result_strobe) begin
				if (expected_q.size() == 0) begin
					flag_error($sformatf("unexpected result kind %0d a %0d b %0d w %0d",
						kind, vertex_a, vertex_b, weight_out));
				end else begin
					want = expected_q.pop_front();
					if (kind !== want.kind)
						flag_error($sformatf("kind %0d, want %0d", kind, want.kind));
					if (vertex_a !== want.va)
						flag_error($sformatf("vertex_a %0d, want %0d", vertex_a, want.va));
					if (vertex_b !== want.vb)
						flag_error($sformatf("vertex_b %0d, want %0d", vertex_b, want.vb));
					if (weight_out !== want.w)
						flag_error($sformatf("weight_out %0d, want %0d", weight_out, want.w));
					if (last !== want.last)
						flag_error($sformatf("last %0d, want %0d", last, want.last));
				end
			end
			if (start && !busy)
				predict_command(mode_t'(mode), int'(source_vertex), int'(dest_vertex),
					edge_weight);
			pending_results <= expected_q.size();
		end
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import amgs_pkg::*;

	// clock and reset
	logic clk = 1'b0;
	logic arst_n = 1'b0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// command side
	logic                start = 1'b0;
	logic                busy;
	logic [MODE_W-1:0]   mode = '0;
	logic [VTX_W-1:0]    source_vertex = '0;
	logic [VTX_W-1:0]    dest_vertex = '0;
	logic [WIN_W-1:0]    edge_weight = '0;

	// result side
	logic                result_strobe;
	logic [KIND_W-1:0]   kind;
	logic [VTX_W-1:0]    vertex_a;
	logic [VTX_W-1:0]    vertex_b;
	logic [WOUT_W-1:0]   weight_out;
	logic                last;

	// register port
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [PADDR_W-1:0]  paddr = '0;
	logic [PDATA_W-1:0]  pwdata = '0;
	logic [PDATA_W-1:0]  prdata;
	logic                pready;

	int unsigned pending_results;
	int unsigned mismatch_count;

	// stimulus bookkeeping
	bit burst = 1'b0;     // no gaps between commands when set
	int live_count = 32;  // vertices in use as the block sees them

	// vertex count of each random phase, mostly small to keep min scans short
	int count_choices [10] = '{1, 2, 3, 5, 8, 8, 6, 16, 32, 40};

	adjacency_matrix_graph_store_unit dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.mode          (mode),
		.source_vertex (source_vertex),
		.dest_vertex   (dest_vertex),
		.edge_weight   (edge_weight),
		.result_strobe (result_strobe),
		.kind          (kind),
		.vertex_a      (vertex_a),
		.vertex_b      (vertex_b),
		.weight_out    (weight_out),
		.last          (last),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready)
	);

	graph_store_checker checker_i (
		.clk             (clk),
		.arst_n          (arst_n),
		.start           (start),
		.busy            (busy),
		.mode            (mode),
		.source_vertex   (source_vertex),
		.dest_vertex     (dest_vertex),
		.edge_weight     (edge_weight),
		.result_strobe   (result_strobe),
		.kind            (kind),
		.vertex_a        (vertex_a),
		.vertex_b        (vertex_b),
		.weight_out      (weight_out),
		.last            (last),
		.psel            (psel),
		.penable         (penable),
		.pwrite          (pwrite),
		.pready          (pready),
		.paddr           (paddr),
		.pwdata          (pwdata),
		.pending_results (pending_results),
		.mismatch_count  (mismatch_count)
	);

	// one command transfer; start stays high after acceptance so a zero gap
	// lets the next command follow without a low cycle
	task automatic issue(mode_t m, int s, int d, int w);
		int gap;
		gap = burst ? 0 : $urandom_range(0, 8);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		mode <= m;
		source_vertex <= VTX_W'(s);
		dest_vertex <= VTX_W'(d);
		edge_weight <= WIN_W'(w);
		// accepted at the first edge that sees busy low
		do @(posedge clk); while (busy);
	endtask

	// drop start and wait for every outstanding result and for busy to clear;
	// the first edge lets the checker count a command taken at this very edge
	task automatic drain();
		start <= 1'b0;
		do @(posedge clk); while (pending_results != 0 || busy);
		repeat (4) @(posedge clk);
	endtask

	// setup phase, access phase, then idle
	task automatic write_reg(reg_idx_t idx, logic [PDATA_W-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	// registers change only once the block has gone quiet
	task automatic configure(bit dir, int count);
		drain();
		write_reg(REG_IS_DIRECTED, PDATA_W'(dir));
		write_reg(REG_VERTEX_COUNT, PDATA_W'(count));
		live_count = (count > MAX_VERTICES_DEF) ? MAX_VERTICES_DEF : count;
	endtask

	// mostly vertices in use, now and then any index to hit the range check
	function automatic int pick_vertex();
		if (live_count == 0 || $urandom_range(0, 9) == 0)
			return $urandom_range(0, 31);
		return $urandom_range(0, live_count - 1);
	endfunction

	task automatic random_command();
		int sel;
		int w;
		sel = $urandom_range(0, 99);
		// small weights now and then so equal weights meet in the min scan
		w = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(0, 65535);
		if (sel < 40)
			issue(M_INSERT, pick_vertex(), pick_vertex(), w);
		else if (sel < 55)
			issue(M_REMOVE, pick_vertex(), pick_vertex(), w);
		else if (sel < 85)
			issue(M_LIST, pick_vertex(), $urandom_range(0, 31), w);
		else
			issue(M_MIN, $urandom_range(0, 31), $urandom_range(0, 31), w);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed graph, all 32 vertices, as after reset
		issue(M_MIN, 0, 0, 0);              // empty graph
		issue(M_LIST, 0, 31, 16'hFFFF);     // vertex without neighbours
		issue(M_INSERT, 0, 31, 16'hFFFF);
		issue(M_INSERT, 31, 0, 0);
		issue(M_INSERT, 5, 5, 16'h1234);    // self loop, one cell
		issue(M_INSERT, 3, 7, 1);
		issue(M_INSERT, 21, 10, 16'h5555);
		issue(M_INSERT, 10, 21, 16'hAAAA);
		issue(M_LIST, 0, 0, 0);
		issue(M_MIN, 31, 31, 0);            // zero weight wins
		issue(M_REMOVE, 31, 0, 0);
		issue(M_REMOVE, 2, 2, 0);           // absent edge still answers done
		issue(M_MIN, 0, 0, 0);

		// undirected, four vertices: mirroring, ties, range errors, hidden cells
		configure(1'b0, 4);
		issue(M_INSERT, 2, 1, 9);
		issue(M_LIST, 1, 0, 0);
		issue(M_INSERT, 3, 0, 9);           // same weight, first in row order wins
		issue(M_INSERT, 4, 0, 1);           // source out of range
		issue(M_LIST, 7, 0, 0);             // listed vertex out of range
		issue(M_REMOVE, 0, 31, 0);          // dest out of range
		issue(M_REMOVE, 1, 2, 0);           // clears both cells
		issue(M_MIN, 0, 0, 0);

		// direction flips with edges stored
		configure(1'b1, 4);
		issue(M_INSERT, 3, 1, 2);
		issue(M_MIN, 0, 0, 0);
		configure(1'b0, 4);
		issue(M_MIN, 0, 0, 0);              // smaller vertex first

		// no vertex in use, then a count above the matrix size
		configure(1'b0, 0);
		issue(M_MIN, 0, 0, 0);
		issue(M_LIST, 0, 0, 0);
		configure(1'b1, 63);
		issue(M_LIST, 3, 0, 0);

		// random phases, each with its own register setting
		for (int p = 0; p < 10; p++) begin
			configure($urandom_range(0, 1), count_choices[p]);
			burst = ($urandom_range(0, 3) == 0);
			for (int k = 0; k < 15; k++)
				random_command();
		end

		// let everything come out, then some margin for stray results
		start <= 1'b0;
		do @(posedge clk); while (pending_results != 0);
		repeat (50) @(posedge clk);

		if (mismatch_count == 0 && pending_results == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// run limit, several times the slowest correct run
	initial begin
		#4000000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
+incdir+src
src/amgs_pkg.sv
src/amgs_ram.sv
src/adjacency_matrix_graph_store_unit.sv
tb/graph_store_checker.sv
tb/tb_top.sv
